// ===== rtl/swa_pkg.sv =====
package swa_pkg;

    // Number of dimension registers; NUM_DIMS of them, the innermost ones, are walked.
    localparam int RANK       = 3;
    localparam int NUM_DIMS   = 3;
    localparam int SIZE_BITS  = 16;

    localparam int SIZE_REG_W = 16;
    localparam int STRIDE_W   = 32;
    localparam int OFFSET_W   = 40;
    localparam int DST_W      = 48;

    localparam int PROD_W     = SIZE_BITS + STRIDE_W;
    localparam int SUM_W      = ((PROD_W > OFFSET_W) ? PROD_W : OFFSET_W) + 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Queue depth must be a power of two (pointers wrap naturally).
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_OFFSET = 3'd0,
        CFG_DIM0_SIZE   = 3'd1,
        CFG_DIM1_SIZE   = 3'd2,
        CFG_DIM2_SIZE   = 3'd3,
        CFG_DIM0_STRIDE = 3'd4,
        CFG_DIM1_STRIDE = 3'd5,
        CFG_DIM2_STRIDE = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [RANK-1:0][SIZE_BITS-1:0] coord;
        logic [DST_W-1:0]               dst;
        logic                           last;
    } t_walk_item;

    function automatic logic dim_active(input int d);
        return d >= (RANK - NUM_DIMS);
    endfunction

endpackage

// ===== rtl/swa_front.sv =====
module swa_front (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_in_valid,
    output logic                                              o_in_ready,
    input  logic                                              i_restart,
    input  logic [swa_pkg::RANK-1:0][swa_pkg::SIZE_REG_W-1:0] i_dim_size,
    input  logic                                              i_q_not_full,
    output logic                                              o_push,
    output swa_pkg::t_walk_item                               o_item
);

    logic [swa_pkg::RANK-1:0][swa_pkg::SIZE_BITS-1:0] r_coord, n_coord;
    logic [swa_pkg::DST_W-1:0]                        r_dst, n_dst;

    logic [swa_pkg::RANK-1:0][swa_pkg::SIZE_BITS-1:0] cur, size_m1;
    logic [swa_pkg::SIZE_BITS-1:0]                    sz;
    logic [swa_pkg::DST_W-1:0]                        dst_cur;
    logic                                             is_last, carry, at_end;

    assign o_in_ready = i_q_not_full;
    assign o_push     = i_in_valid && i_q_not_full;

    always_comb begin
        is_last = 1'b1;
        carry   = 1'b1;
        dst_cur = i_restart ? '0 : r_dst;
        for (int d = 0; d < swa_pkg::RANK; d++) begin
            sz         = i_dim_size[d][swa_pkg::SIZE_BITS-1:0];
            // zero size behaves as size 1; inactive dims are size 1, coord 0
            size_m1[d] = (!swa_pkg::dim_active(d) || sz == '0) ? '0 : sz - 1'b1;
            cur[d]     = (i_restart || !swa_pkg::dim_active(d)) ? '0 : r_coord[d];
            if (cur[d] != size_m1[d]) begin
                is_last = 1'b0;
            end
        end
        // odometer, innermost first; a coord at or past its last value wraps
        for (int d = swa_pkg::RANK - 1; d >= 0; d--) begin
            at_end     = cur[d] >= size_m1[d];
            n_coord[d] = cur[d];
            if (carry && swa_pkg::dim_active(d)) begin
                n_coord[d] = at_end ? '0 : cur[d] + 1'b1;
            end
            carry = carry && swa_pkg::dim_active(d) && at_end;
        end
        n_dst = dst_cur + 1'b1;
        if (is_last) begin
            n_coord = '0;
            n_dst   = '0;
        end
    end

    assign o_item.coord = cur;
    assign o_item.dst   = dst_cur;
    assign o_item.last  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
            r_dst   <= '0;
        end else if (o_push) begin
            r_coord <= n_coord;
            r_dst   <= n_dst;
        end
    end

endmodule

// ===== rtl/swa_queue.sv =====
module swa_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  swa_pkg::t_walk_item i_item,
    output logic                o_not_full,
    input  logic                i_pop,
    output swa_pkg::t_walk_item o_item,
    output logic                o_not_empty
);

    swa_pkg::t_walk_item r_mem [swa_pkg::QUEUE_DEPTH];
    logic [swa_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [swa_pkg::QCNT_W-1:0] r_count;

    assign o_not_full  = r_count != swa_pkg::QCNT_W'(swa_pkg::QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_item      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/swa_back.sv =====
module swa_back (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic [swa_pkg::OFFSET_W-1:0]                    i_base_offset,
    input  logic [swa_pkg::RANK-1:0][swa_pkg::STRIDE_W-1:0] i_dim_stride,
    input  logic                                            i_q_not_empty,
    input  swa_pkg::t_walk_item                             i_item,
    output logic                                            o_pop,
    output logic                                            o_out_valid,
    input  logic                                            i_out_ready,
    output logic [swa_pkg::OFFSET_W-1:0]                    o_src_offset,
    output logic [swa_pkg::DST_W-1:0]                       o_dst_index,
    output logic                                            o_last_element,
    output logic                                            o_out_of_range
);

    // stage 1: products
    logic                                          r_v1;
    logic [swa_pkg::RANK-1:0][swa_pkg::PROD_W-1:0] r_prod;
    logic [swa_pkg::DST_W-1:0]                     r_dst1;
    logic                                          r_last1;
    // stage 2: pairwise sums
    logic                                          r_v2;
    logic [swa_pkg::SUM_W-1:0]                     r_sum_a, r_sum_b;
    logic [swa_pkg::DST_W-1:0]                     r_dst2;
    logic                                          r_last2;
    // stage 3: output register
    logic                                          r_v3;
    logic [swa_pkg::SUM_W-1:0]                     r_sum;
    logic [swa_pkg::DST_W-1:0]                     r_dst3;
    logic                                          r_last3;

    logic en1, en2, en3;

    assign en3   = !r_v3 || i_out_ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_q_not_empty && en1;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int d = 0; d < swa_pkg::RANK; d++) begin
                r_prod[d] <= swa_pkg::PROD_W'(i_item.coord[d])
                           * swa_pkg::PROD_W'(i_dim_stride[d]);
            end
            r_dst1  <= i_item.dst;
            r_last1 <= i_item.last;
        end
        if (en2) begin
            r_sum_a <= swa_pkg::SUM_W'(r_prod[0]) + swa_pkg::SUM_W'(r_prod[1]);
            r_sum_b <= swa_pkg::SUM_W'(r_prod[2]) + swa_pkg::SUM_W'(i_base_offset);
            r_dst2  <= r_dst1;
            r_last2 <= r_last1;
        end
        if (en3) begin
            r_sum   <= r_sum_a + r_sum_b;
            r_dst3  <= r_dst2;
            r_last3 <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_q_not_empty;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    assign o_out_valid    = r_v3;
    assign o_src_offset   = r_sum[swa_pkg::OFFSET_W-1:0];
    assign o_out_of_range = |r_sum[swa_pkg::SUM_W-1:swa_pkg::OFFSET_W];
    assign o_dst_index    = r_dst3;
    assign o_last_element = r_last3;

endmodule

// ===== rtl/strided_view_address_walker.sv =====
// Strided view address walker: emits one source element offset per input item,
// walking a (up to) three-dimensional strided view in row-major order, plus the
// contiguous destination index and a last flag. Each item carries a restart bit
// that zeroes the coordinates and destination counter before the element is
// produced. Rate: one item per clock in both directions while nothing stalls;
// an item reaches the output register through the queue and the back end.
// The front end (odometer) updates its coordinates in the cycle an item is
// accepted; a four-item queue separates it from a three-stage back end
// (coordinate x stride products, two partial sums, final add into the output
// register), so either side can stall without stopping the other. Offsets
// whose true value needs more than 40 bits are wrapped and flagged with
// out_of_range. Configuration is a plain write port (index 0 base offset,
// 1..3 sizes, 4..6 strides) and must only be written while the block is idle.
module strided_view_address_walker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [swa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [swa_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // step items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_restart,
    // address items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [swa_pkg::OFFSET_W-1:0]       o_src_offset,
    output logic [swa_pkg::DST_W-1:0]          o_dst_index,
    output logic                               o_last_element,
    output logic                               o_out_of_range
);

    // ---------------- configuration registers ----------------
    logic [swa_pkg::OFFSET_W-1:0]                      r_base_offset;
    logic [swa_pkg::RANK-1:0][swa_pkg::SIZE_REG_W-1:0] r_dim_size;
    logic [swa_pkg::RANK-1:0][swa_pkg::STRIDE_W-1:0]   r_dim_stride;

    // Reset: sizes 1, innermost stride 1, everything else 0.
    // Indexes past the list are dropped; data bits above a register's width too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_offset <= '0;
            r_dim_size[0] <= swa_pkg::SIZE_REG_W'(1);
            r_dim_size[1] <= swa_pkg::SIZE_REG_W'(1);
            r_dim_size[2] <= swa_pkg::SIZE_REG_W'(1);
            r_dim_stride[0] <= '0;
            r_dim_stride[1] <= '0;
            r_dim_stride[2] <= swa_pkg::STRIDE_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                swa_pkg::CFG_BASE_OFFSET:
                    r_base_offset <= i_cfg_wdata[swa_pkg::OFFSET_W-1:0];
                swa_pkg::CFG_DIM0_SIZE:
                    r_dim_size[0] <= i_cfg_wdata[swa_pkg::SIZE_REG_W-1:0];
                swa_pkg::CFG_DIM1_SIZE:
                    r_dim_size[1] <= i_cfg_wdata[swa_pkg::SIZE_REG_W-1:0];
                swa_pkg::CFG_DIM2_SIZE:
                    r_dim_size[2] <= i_cfg_wdata[swa_pkg::SIZE_REG_W-1:0];
                swa_pkg::CFG_DIM0_STRIDE:
                    r_dim_stride[0] <= i_cfg_wdata[swa_pkg::STRIDE_W-1:0];
                swa_pkg::CFG_DIM1_STRIDE:
                    r_dim_stride[1] <= i_cfg_wdata[swa_pkg::STRIDE_W-1:0];
                swa_pkg::CFG_DIM2_STRIDE:
                    r_dim_stride[2] <= i_cfg_wdata[swa_pkg::STRIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- front: odometer ----------------
    swa_pkg::t_walk_item w_push_item, w_pop_item;
    logic                w_push, w_pop, w_q_not_full, w_q_not_empty;

    swa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_restart    (i_restart),
        .i_dim_size   (r_dim_size),
        .i_q_not_full (w_q_not_full),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    // ---------------- queue between front and back ----------------
    swa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_push_item),
        .o_not_full  (w_q_not_full),
        .i_pop       (w_pop),
        .o_item      (w_pop_item),
        .o_not_empty (w_q_not_empty)
    );

    // ---------------- back: offset arithmetic ----------------
    swa_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_base_offset  (r_base_offset),
        .i_dim_stride   (r_dim_stride),
        .i_q_not_empty  (w_q_not_empty),
        .i_item         (w_pop_item),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_src_offset   (o_src_offset),
        .o_dst_index    (o_dst_index),
        .o_last_element (o_last_element),
        .o_out_of_range (o_out_of_range)
    );

    // ---------------- assertions ----------------
    // A restart item always starts at the origin with destination index zero.
    a_restart_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_restart)
            |-> (w_push_item.dst == '0 && w_push_item.coord == '0))
        else $error("restart item not at origin");

    // A full queue can never also read as empty.
    a_queue_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_q_not_full |-> w_q_not_empty)
        else $error("queue full and empty at once");

    // The output register only drains through a completed handshake.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("output item dropped");

    // Nothing is pushed into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_not_full)
        else $error("queue overflow");

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Index 7 is not a register; writes there must leave the walk alone.
    localparam logic [swa_pkg::CFG_IDX_W-1:0]  CFG_IDX_UNUSED = 3'd7;
    localparam logic [swa_pkg::CFG_DATA_W-1:0] OFFSET_MAX =
        (40'd1 << swa_pkg::OFFSET_W) - 40'd1;
    localparam logic [swa_pkg::CFG_DATA_W-1:0] STRIDE_MAX =
        (40'd1 << swa_pkg::STRIDE_W) - 40'd1;
    localparam logic [swa_pkg::CFG_DATA_W-1:0] SIZE_MAX =
        (40'd1 << swa_pkg::SIZE_BITS) - 40'd1;
    // Output register sits behind the queue and the back-end stages; allow some slack.
    localparam int SETTLE_CYCLES = 10;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [swa_pkg::OFFSET_W-1:0] src;
        logic [swa_pkg::DST_W-1:0]    dst;
        logic                         last;
        logic                         oor;
    } t_addr;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [swa_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [swa_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                           i_in_valid;
    logic                           o_in_ready;
    logic                           i_restart;
    logic                           o_out_valid;
    logic                           i_out_ready;
    logic [swa_pkg::OFFSET_W-1:0]   o_src_offset;
    logic [swa_pkg::DST_W-1:0]      o_dst_index;
    logic                           o_last_element;
    logic                           o_out_of_range;

    strided_view_address_walker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_src_offset   (o_src_offset),
        .o_dst_index    (o_dst_index),
        .o_last_element (o_last_element),
        .o_out_of_range (o_out_of_range)
    );

    // Shadow copy of the view registers and of the odometer.
    logic [swa_pkg::OFFSET_W-1:0]   cfg_base;
    logic [swa_pkg::SIZE_REG_W-1:0] cfg_size   [swa_pkg::RANK];
    logic [swa_pkg::STRIDE_W-1:0]   cfg_stride [swa_pkg::RANK];
    logic [swa_pkg::SIZE_BITS-1:0]  walk_coord [swa_pkg::RANK];
    logic [swa_pkg::DST_W-1:0]      walk_dst;

    // Addresses predicted for accepted items, oldest first.
    t_addr exp_addr_q[$];
    int    n_mismatch;

    // Flow control knobs of the sender and the ready driver; tests set some of them.
    int rx_hold;   // long hold-off requested by a test, counted down per cycle
    int rx_stall;
    int rx_calm;
    int tx_calm;
    bit tx_burst;  // sender offers back to back while set

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

    // Extent of dimension d as the walk sees it: leading inactive dims and
    // zero sizes count as one, and only SIZE_BITS bits of a size matter.
    function automatic logic [swa_pkg::SIZE_BITS:0] eff_extent(input int d);
        logic [swa_pkg::SIZE_BITS-1:0] s;
        if (d < swa_pkg::RANK - swa_pkg::NUM_DIMS) return (swa_pkg::SIZE_BITS+1)'(1);
        s = cfg_size[d][swa_pkg::SIZE_BITS-1:0];
        return (s == '0) ? (swa_pkg::SIZE_BITS+1)'(1) : {1'b0, s};
    endfunction

    // Address of the current element, then odometer advance (innermost first).
    function automatic t_addr walk_predict(input logic restart);
        t_addr                       r;
        logic [63:0]                 sum;
        logic [swa_pkg::SIZE_BITS:0] nxt;
        logic                        at_end;
        if (restart) begin
            for (int d = 0; d < swa_pkg::RANK; d++) walk_coord[d] = '0;
            walk_dst = '0;
        end
        sum    = 64'(cfg_base);
        at_end = 1'b1;
        for (int d = 0; d < swa_pkg::RANK; d++) begin
            if (d < swa_pkg::RANK - swa_pkg::NUM_DIMS) walk_coord[d] = '0;
            sum += 64'(walk_coord[d]) * 64'(cfg_stride[d]);
            // a coordinate left past a lowered size never counts as last
            if ({1'b0, walk_coord[d]} != eff_extent(d) - 1'b1) at_end = 1'b0;
        end
        r.src  = sum[swa_pkg::OFFSET_W-1:0];
        r.dst  = walk_dst;
        r.last = at_end;
        r.oor  = (sum >> swa_pkg::OFFSET_W) != 0;
        if (at_end) begin
            for (int d = 0; d < swa_pkg::RANK; d++) walk_coord[d] = '0;
            walk_dst = '0;
        end else begin
            for (int d = swa_pkg::RANK - 1; d >= swa_pkg::RANK - swa_pkg::NUM_DIMS; d--) begin
                nxt = {1'b0, walk_coord[d]} + 1'b1;
                if (nxt < eff_extent(d)) begin
                    walk_coord[d] = nxt[swa_pkg::SIZE_BITS-1:0];
                    break;
                end
                walk_coord[d] = '0;
            end
            walk_dst = walk_dst + 1'b1;
        end
        return r;
    endfunction

    // Sender gap: mostly none, some short, a few long, plus calm stretches.
    function automatic int tx_gap();
        int r;
        if (tx_burst) return 0;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tx_calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Register write; the shadow copy keeps only the bits the register holds.
    task automatic write_reg(input logic [swa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swa_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            swa_pkg::CFG_BASE_OFFSET: cfg_base      = val[swa_pkg::OFFSET_W-1:0];
            swa_pkg::CFG_DIM0_SIZE:   cfg_size[0]   = val[swa_pkg::SIZE_REG_W-1:0];
            swa_pkg::CFG_DIM1_SIZE:   cfg_size[1]   = val[swa_pkg::SIZE_REG_W-1:0];
            swa_pkg::CFG_DIM2_SIZE:   cfg_size[2]   = val[swa_pkg::SIZE_REG_W-1:0];
            swa_pkg::CFG_DIM0_STRIDE: cfg_stride[0] = val[swa_pkg::STRIDE_W-1:0];
            swa_pkg::CFG_DIM1_STRIDE: cfg_stride[1] = val[swa_pkg::STRIDE_W-1:0];
            swa_pkg::CFG_DIM2_STRIDE: cfg_stride[2] = val[swa_pkg::STRIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic [swa_pkg::CFG_DATA_W-1:0] base,
                            input logic [swa_pkg::CFG_DATA_W-1:0] s0, s1, s2,
                            input logic [swa_pkg::CFG_DATA_W-1:0] t0, t1, t2);
        write_reg(swa_pkg::CFG_BASE_OFFSET, base);
        write_reg(swa_pkg::CFG_DIM0_SIZE, s0);
        write_reg(swa_pkg::CFG_DIM1_SIZE, s1);
        write_reg(swa_pkg::CFG_DIM2_SIZE, s2);
        write_reg(swa_pkg::CFG_DIM0_STRIDE, t0);
        write_reg(swa_pkg::CFG_DIM1_STRIDE, t1);
        write_reg(swa_pkg::CFG_DIM2_STRIDE, t2);
    endtask

    // Offer one step item; valid stays up across back-to-back items so it
    // only ever gets one update per falling edge.
    task automatic send_step(input logic restart);
        int gap;
        gap = tx_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_restart  <= 1'($urandom);  // noise on the idle payload
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart  <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        exp_addr_q.insert(exp_addr_q.size(), walk_predict(restart));
    endtask

    // Drop valid and let every outstanding address come back.
    task automatic wait_walk_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (exp_addr_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [swa_pkg::CFG_DATA_W-1:0] rand_junk40();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[swa_pkg::CFG_DATA_W-1:0];
    endfunction

    // Sizes are kept small so walks wrap often; junk rides in the upper bits.
    function automatic logic [swa_pkg::CFG_DATA_W-1:0] rand_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return rand_junk40();
        if (r == 1) return {24'($urandom), 16'd0};
        if (r == 2) return SIZE_MAX;
        return {24'($urandom), 16'($urandom_range(1, 4))};
    endfunction

    function automatic logic [swa_pkg::CFG_DATA_W-1:0] rand_stride();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return STRIDE_MAX;
        return rand_junk40();
    endfunction

    function automatic logic [swa_pkg::CFG_DATA_W-1:0] rand_base();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return '0;
        if (r == 1) return OFFSET_MAX;
        return rand_junk40();
    endfunction

    // Out of reset: 1x1x1 view at offset 0, every item is the last element.
    task automatic test_reset_view();
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        wait_walk_idle();
    endtask

    task automatic test_corner_views();
        // Max base and max strides: the sum runs past 40 bits and wraps.
        set_view(OFFSET_MAX, 40'd2, 40'd1, 40'd3, STRIDE_MAX, STRIDE_MAX, STRIDE_MAX);
        send_step(1'b1);
        repeat (5) send_step(1'b0);
        wait_walk_idle();
        // Zero sizes act as one, junk above the register width is dropped,
        // and a write to the unused index changes nothing.
        set_view('0, 40'hAB_CDEF_0000, 40'd0, SIZE_MAX, 40'hFF_0000_1234, '0, STRIDE_MAX);
        write_reg(CFG_IDX_UNUSED, rand_junk40());
        send_step(1'b1);
        send_step(1'b0);
        send_step(1'b1);
        send_step(1'b0);
        wait_walk_idle();
        // Shrink the inner size mid-walk: the stale coordinate is not last
        // and carries into the middle dimension on the next advance.
        set_view(40'd100, 40'd1, 40'd2, 40'd10, 40'd7, 40'd10, 40'd1);
        send_step(1'b1);
        repeat (6) send_step(1'b0);
        wait_walk_idle();
        write_reg(swa_pkg::CFG_DIM2_SIZE, 40'd4);
        repeat (5) send_step(1'b0);
        wait_walk_idle();
    endtask

    // Receiver holds off while the sender keeps pushing: queue fills and
    // o_in_ready must drop without losing or duplicating items.
    task automatic test_input_stall();
        set_view(rand_base(), 40'd2, 40'd3, 40'd4, rand_stride(), rand_stride(), rand_stride());
        rx_hold  = 80;
        tx_burst = 1'b1;
        send_step(1'b1);
        repeat (23) send_step(1'b0);
        tx_burst = 1'b0;
        wait_walk_idle();
    endtask

    // Mostly continuing walks over random views, with occasional restarts.
    task automatic test_random_walks();
        for (int p = 0; p < 9; p++) begin
            set_view(rand_base(), rand_size(), rand_size(), rand_size(),
                     rand_stride(), rand_stride(), rand_stride());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_UNUSED, rand_junk40());
            send_step(1'($urandom));
            repeat (54) send_step($urandom_range(0, 24) == 0);
            wait_walk_idle();
        end
    endtask

    // Output ready: test hold-offs first, then random stalls and calm runs.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (rx_calm > 0) begin
                    rx_calm--;
                end else begin
                    case ($urandom_range(0, 39))
                        0:       rx_calm  = $urandom_range(20, 80);
                        1:       rx_stall = $urandom_range(6, 30);
                        2, 3, 4,
                        5, 6, 7: rx_stall = $urandom_range(1, 3);
                        default: ;
                    endcase
                end
            end
        end
    end

    // Compare every accepted address item with the oldest prediction.
    always @(posedge i_clk) begin : check_addr
        t_addr e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_addr_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= REPORT_LIMIT)
                    $display("unexpected item: src=%h dst=%h last=%b oor=%b",
                             o_src_offset, o_dst_index, o_last_element, o_out_of_range);
            end else begin
                e = exp_addr_q.pop_front();
                if (o_src_offset !== e.src || o_dst_index !== e.dst ||
                    o_last_element !== e.last || o_out_of_range !== e.oor) begin
                    n_mismatch++;
                    if (n_mismatch <= REPORT_LIMIT)
                        $display("mismatch: src %h/%h dst %h/%h last %b/%b oor %b/%b",
                                 e.src, o_src_offset, e.dst, o_dst_index,
                                 e.last, o_last_element, e.oor, o_out_of_range);
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_restart   = 1'b0;
        n_mismatch  = 0;
        rx_hold     = 0;
        rx_stall    = 0;
        rx_calm     = 0;
        tx_calm     = 0;
        tx_burst    = 1'b0;
        // register reset values: unit view, unit inner stride
        cfg_base = '0;
        for (int d = 0; d < swa_pkg::RANK; d++) begin
            cfg_size[d]   = swa_pkg::SIZE_REG_W'(1);
            cfg_stride[d] = '0;
            walk_coord[d] = '0;
        end
        cfg_stride[swa_pkg::RANK-1] = swa_pkg::STRIDE_W'(1);
        walk_dst = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_view();
        test_corner_views();
        test_input_stall();
        test_random_walks();
        wait_walk_idle();

        if (n_mismatch == 0 && exp_addr_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swa_pkg.sv
rtl/swa_front.sv
rtl/swa_queue.sv
rtl/swa_back.sv
rtl/strided_view_address_walker.sv
tb/tb.sv
